>>> rtl/lrjs_pkg.sv
// shared constants and types for the largest remaining job scheduler
`timescale 1ns / 1ps
`default_nettype none

package lrjs_pkg;

    localparam int NUM_JOBS      = 16;
    localparam int TIME_BITS     = 16;
    localparam int IDX_BITS      = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam int CNT_BITS      = $clog2(NUM_JOBS + 1);

    // fixed widths of the port fields
    localparam int CFG_BITS      = 5;
    localparam int JOB_FLD_BITS  = 4;
    localparam int TIME_FLD_BITS = 16;

    localparam int ACTIVE_RESET  = 16;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> rtl/largest_remaining_job_scheduler_unit.sv
// largest remaining job scheduler: job table in two rams, sequential max scan
//
// input channel (in_valid / in_stall) carries one beat per item. a load beat
// (kind 0) writes remaining time and quantum of job_index in the cycle it is
// taken and gives no result; a job_index beyond the table is dropped.
// a run beat (kind 1) scans the active entries, one ram read per cycle, picks
// the largest non-zero remaining time (lowest index on ties), subtracts its
// quantum floored at zero, writes it back and emits one result beat.
// a run item keeps in_stall high through the scan and finish states, so no new
// item is taken until its result is registered on leaving finish; the scan goes
// through the single read port of the remaining time ram.
// output channel (out_valid / out_stall) is registered; while the receiver
// stalls the result holds and a finished run waits, so in_stall stays high.
// cfg channel (cfg_valid / cfg_ready) writes active_jobs, always ready;
// values above the table size act as the table size.
// reset: active_jobs returns to 16, no result pending, the table contents
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module largest_remaining_job_scheduler_unit
    import lrjs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_BITS-1:0]      cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     kind,
    input  wire logic [JOB_FLD_BITS-1:0]  job_index,
    input  wire logic [TIME_FLD_BITS-1:0] time_needed,
    input  wire logic [TIME_FLD_BITS-1:0] run_quantum,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [JOB_FLD_BITS-1:0]  served_job,
    output logic      [TIME_FLD_BITS-1:0] time_left,
    output logic                          idle
);

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]      active_jobs_reg;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic [CNT_BITS-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [IDX_BITS-1:0]      pend_idx_reg, pend_idx_next;
    logic                     found_reg, found_next;
    logic [IDX_BITS-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]     best_time_reg, best_time_next;
    logic [TIME_BITS-1:0]     best_q_reg, best_q_next;

    logic                     out_valid_reg, out_valid_next;
    logic [JOB_FLD_BITS-1:0]  served_job_reg, served_job_next;
    logic [TIME_FLD_BITS-1:0] time_left_reg, time_left_next;
    logic                     idle_reg, idle_next;

    logic                     in_take;
    logic                     load_ok;
    logic                     out_free;
    logic [TIME_BITS-1:0]     left;

    logic                     rt_wr_en;
    logic [IDX_BITS-1:0]      rt_wr_addr;
    logic [TIME_BITS-1:0]     rt_wr_data;
    logic                     q_wr_en;
    logic                     rd_en;
    logic [IDX_BITS-1:0]      rd_addr;
    logic [TIME_BITS-1:0]     rt_rd_data;
    logic [TIME_BITS-1:0]     q_rd_data;

    lrjs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_JOBS)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (rt_wr_en),
        .wr_addr (rt_wr_addr),
        .wr_data (rt_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rt_rd_data)
    );

    lrjs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_JOBS)
    ) u_quantum_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (IDX_BITS'(job_index)),
        .wr_data (TIME_BITS'(run_quantum)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (q_rd_data)
    );

    assign in_take  = in_valid && !in_stall;
    assign load_ok  = 32'(job_index) < NUM_JOBS;
    assign out_free = !out_valid_reg || !out_stall;
    assign left     = (best_time_reg > best_q_reg) ? (best_time_reg - best_q_reg)
                                                   : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take && kind == KIND_RUN)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue_cnt_reg == count_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and ram control
    always_comb
    begin
        in_stall   = 1'b1;
        rt_wr_en   = 1'b0;
        rt_wr_addr = IDX_BITS'(job_index);
        rt_wr_data = TIME_BITS'(time_needed);
        q_wr_en    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = issue_cnt_reg[IDX_BITS-1:0];
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && kind == KIND_LOAD && load_ok)
                begin
                    rt_wr_en = 1'b1;
                    q_wr_en  = 1'b1;
                end
            end
            S_SCAN:
            begin
                rd_en = issue_cnt_reg < count_reg;
            end
            S_FINISH:
            begin
                // write back only once the result can leave
                rt_wr_en   = out_free && found_reg;
                rt_wr_addr = best_idx_reg;
                rt_wr_data = left;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next      = count_reg;
        issue_cnt_next  = issue_cnt_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        best_q_next     = best_q_reg;
        out_valid_next  = out_valid_reg && out_stall;
        served_job_next = served_job_reg;
        time_left_next  = time_left_reg;
        idle_next       = idle_reg;

        if (state_reg == S_IDLE)
        begin
            count_next     = (32'(active_jobs_reg) > NUM_JOBS) ? CNT_BITS'(NUM_JOBS)
                                                               : CNT_BITS'(active_jobs_reg);
            issue_cnt_next = '0;
            found_next     = 1'b0;
        end

        if (state_reg == S_SCAN)
        begin
            if (rd_en)
            begin
                issue_cnt_next  = issue_cnt_reg + 1'b1;
                pend_valid_next = 1'b1;
                pend_idx_next   = rd_addr;
            end
            // compare the beat read last cycle
            if (pend_valid_reg && rt_rd_data != '0
                && (!found_reg || rt_rd_data > best_time_reg))
            begin
                found_next     = 1'b1;
                best_idx_next  = pend_idx_reg;
                best_time_next = rt_rd_data;
                best_q_next    = q_rd_data;
            end
        end

        if (state_reg == S_FINISH && out_free)
        begin
            out_valid_next = 1'b1;
            if (found_reg)
            begin
                served_job_next = JOB_FLD_BITS'(best_idx_reg);
                time_left_next  = TIME_FLD_BITS'(left);
                idle_next       = 1'b0;
            end
            else
            begin
                served_job_next = '0;
                time_left_next  = '0;
                idle_next       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_jobs_reg <= CFG_BITS'(ACTIVE_RESET);
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            issue_cnt_reg   <= '0;
            count_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            issue_cnt_reg  <= issue_cnt_next;
            count_reg      <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                active_jobs_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_time_reg  <= best_time_next;
        best_q_reg     <= best_q_next;
        served_job_reg <= served_job_next;
        time_left_reg  <= time_left_next;
        idle_reg       <= idle_next;
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign served_job = served_job_reg;
    assign time_left  = time_left_reg;
    assign idle       = idle_reg;

`ifndef SYNTH
    a_run_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && kind == KIND_RUN) |=> (state_reg == S_SCAN && issue_cnt_reg == '0))
        else $error("run beat did not start a scan");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= count_reg))
        else $error("scan issued past the active count");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ($past(state_reg) == S_SCAN && $past(rd_en)))
        else $error("compare without a matching read");

    a_writeback_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && rt_wr_en) |-> (found_reg && out_free))
        else $error("write back without a served job");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("result beat outside finish");
`endif

endmodule

`default_nettype wire

>>> rtl/lrjs_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lrjs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

>>> bench/largest_remaining_job_scheduler_unit_tb.sv
// self-checking bench for the largest remaining job scheduler unit
`timescale 1ns / 1ps

module largest_remaining_job_scheduler_unit_tb;
    import lrjs_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_WAIT  = 30;
    localparam int ITEMS_PHASE  = 110;

    typedef struct packed {
        logic [JOB_FLD_BITS-1:0]  job;
        logic [TIME_FLD_BITS-1:0] left;
        logic                     idle;
    } sched_result_t;

    class lrjs_scoreboard;
        logic [TIME_BITS-1:0] rem_time [NUM_JOBS];
        logic [TIME_BITS-1:0] quantum [NUM_JOBS];
        logic [CFG_BITS-1:0]  active;
        sched_result_t        served_q [$];
        int                   mismatches;

        function new();
            active = CFG_BITS'(ACTIVE_RESET);
            mismatches = 0;
            foreach (rem_time[i])
            begin
                rem_time[i] = '0;
                quantum[i] = '0;
            end
        endfunction

        function void set_active(logic [CFG_BITS-1:0] v);
            active = v;
        endfunction

        function int pending();
            return served_q.size();
        endfunction

        function int scan_count();
            return (int'(active) > NUM_JOBS) ? NUM_JOBS : int'(active);
        endfunction

        // one accepted input beat: loads update the table, runs pick the largest job
        function void note_item(logic k, logic [JOB_FLD_BITS-1:0] j,
                                logic [TIME_FLD_BITS-1:0] t, logic [TIME_FLD_BITS-1:0] q);
            sched_result_t        res;
            int                   best;
            logic [TIME_BITS-1:0] best_time;
            bit                   found;
            if (k == KIND_LOAD)
            begin
                if (int'(j) < NUM_JOBS)
                begin
                    rem_time[j] = t[TIME_BITS-1:0];
                    quantum[j] = q[TIME_BITS-1:0];
                end
                return;
            end
            best = 0;
            best_time = '0;
            found = 0;
            for (int i = 0; i < scan_count(); i++)
            begin
                // strict compare keeps the lowest index on ties
                if (rem_time[i] != '0 && (!found || rem_time[i] > best_time))
                begin
                    found = 1;
                    best = i;
                    best_time = rem_time[i];
                end
            end
            if (!found)
            begin
                res.job = '0;
                res.left = '0;
                res.idle = 1'b1;
            end
            else
            begin
                rem_time[best] = (best_time > quantum[best]) ? best_time - quantum[best] : '0;
                res.job = JOB_FLD_BITS'(best);
                res.left = TIME_FLD_BITS'(rem_time[best]);
                res.idle = 1'b0;
            end
            served_q.push_back(res);
        endfunction

        function void check_result(logic [JOB_FLD_BITS-1:0] j, logic [TIME_FLD_BITS-1:0] l,
                                   logic idl);
            sched_result_t want;
            if (served_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: job %0d left %0d idle %0d", j, l, idl);
                return;
            end
            want = served_q.pop_front();
            if (want.job !== j || want.left !== l || want.idle !== idl)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected job %0d left %0d idle %0d, got job %0d left %0d idle %0d",
                             want.job, want.left, want.idle, j, l, idl);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_BITS-1:0]      cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     kind;
    logic [JOB_FLD_BITS-1:0]  job_index;
    logic [TIME_FLD_BITS-1:0] time_needed;
    logic [TIME_FLD_BITS-1:0] run_quantum;
    logic                     out_valid;
    logic                     out_stall;
    logic [JOB_FLD_BITS-1:0]  served_job;
    logic [TIME_FLD_BITS-1:0] time_left;
    logic                     idle;

    lrjs_scoreboard sched_sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_done;
    int hold_left;
    int quiet_cycles;

    largest_remaining_job_scheduler_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .job_index   (job_index),
        .time_needed (time_needed),
        .run_quantum (run_quantum),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .served_job  (served_job),
        .time_left   (time_left),
        .idle        (idle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_done)
        begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sched_sb.check_result(served_job, time_left, idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("no beat for %0d cycles", IDLE_LIMIT);
            $display("[largest_remaining_job_scheduler_unit] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic k, input logic [JOB_FLD_BITS-1:0] j,
                             input logic [TIME_FLD_BITS-1:0] t,
                             input logic [TIME_FLD_BITS-1:0] q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        job_index <= j;
        time_needed <= t;
        run_quantum <= q;
        do
            @(posedge clk);
        while (in_stall);
        sched_sb.note_item(k, j, t, q);
    endtask

    // stop offering, let every result come back and the unit settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sched_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_active(input logic [CFG_BITS-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sched_sb.set_active(v);
    endtask

    function automatic logic [TIME_FLD_BITS-1:0] rand_time();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return TIME_FLD_BITS'($urandom_range(1, 20));
            default: return TIME_FLD_BITS'($urandom);
        endcase
    endfunction

    // small quanta dominate so jobs live through several runs
    function automatic logic [TIME_FLD_BITS-1:0] rand_quantum();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return TIME_FLD_BITS'($urandom_range(1, 8));
            default: return TIME_FLD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [JOB_FLD_BITS-1:0] pick_job();
        int cnt;
        cnt = sched_sb.scan_count();
        if (cnt > 0 && $urandom_range(0, 9) < 8)
            return JOB_FLD_BITS'($urandom_range(0, cnt - 1));
        return JOB_FLD_BITS'($urandom_range(0, NUM_JOBS - 1));
    endfunction

    // bursts of loads followed by runs, with a little noise mixed in
    task automatic random_phase(input int n_items);
        int sent;
        int n_load;
        int n_run;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(1'($urandom), JOB_FLD_BITS'($urandom), rand_time(), rand_quantum());
                sent++;
            end
            else
            begin
                n_load = $urandom_range(1, 4);
                n_run = $urandom_range(1, 6);
                for (int i = 0; i < n_load; i++)
                    send_item(KIND_LOAD, pick_job(), rand_time(), rand_quantum());
                for (int i = 0; i < n_run; i++)
                    send_item(KIND_RUN, JOB_FLD_BITS'($urandom), TIME_FLD_BITS'($urandom),
                              TIME_FLD_BITS'($urandom));
                sent += n_load + n_run;
            end
        end
    endtask

    initial
    begin
        logic [TIME_FLD_BITS-1:0] t;
        logic [TIME_FLD_BITS-1:0] q;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_LOAD;
        job_index = '0;
        time_needed = '0;
        run_quantum = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        holds_done = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table first so no run scans an unloaded entry
        for (int j = 0; j < NUM_JOBS; j++)
        begin
            t = (j < 2) ? 16'hFFFF : (j == 2) ? 16'h0000 : (j == 15) ? 16'h0001
                : TIME_FLD_BITS'(j * 16'h0AAA);
            q = (j == 0) ? 16'h0000 : (j == 1 || j == 15) ? 16'hFFFF
                : TIME_FLD_BITS'(16'h8000 >> j);
            send_item(KIND_LOAD, JOB_FLD_BITS'(j), t, q);
        end
        // zero quantum keeps job 0 on top, then the tie with job 1 goes to job 0
        send_item(KIND_RUN, '0, '0, '0);
        send_item(KIND_RUN, '1, '1, '1);
        send_item(KIND_LOAD, 4'd0, 16'h0000, 16'h0000);
        // job 1 drops exactly to zero
        send_item(KIND_RUN, '0, '0, '0);
        send_item(KIND_RUN, '0, '0, '0);
        // a single active entry holding zero gives idle
        write_active(5'd1);
        send_item(KIND_RUN, '0, '0, '0);
        // quantum larger than the time left floors at zero
        send_item(KIND_LOAD, 4'd0, 16'h0003, 16'h0010);
        send_item(KIND_RUN, '0, '0, '0);
        send_item(KIND_RUN, '0, '0, '0);
        write_active(5'd0);
        send_item(KIND_RUN, '0, '0, '0);
        // beyond the table size acts as the whole table
        write_active(5'd31);
        send_item(KIND_RUN, '0, '0, '0);

        write_active(5'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(ITEMS_PHASE);

        write_active(5'd1);
        send_idle_pct = 88;
        recv_stall_pct = 0;
        random_phase(ITEMS_PHASE / 2);

        write_active(5'd31);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        random_phase(ITEMS_PHASE);

        write_active(CFG_BITS'($urandom_range(2, 15)));
        send_idle_pct = 38;
        recv_stall_pct = 38;
        random_phase(ITEMS_PHASE);

        // long receiver hold-off while items keep coming
        write_active(CFG_BITS'($urandom_range(0, 31)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = hold_requests + 1;
        random_phase(ITEMS_PHASE);

        write_active(5'd16);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        random_phase(ITEMS_PHASE / 2);

        drain();
        if (sched_sb.pending() != 0)
            $display("%0d results never arrived", sched_sb.pending());
        if (sched_sb.mismatches == 0 && sched_sb.pending() == 0)
            $display("[largest_remaining_job_scheduler_unit] OK");
        else
            $display("[largest_remaining_job_scheduler_unit] ERROR");
        $finish;
    end

endmodule
